### rtl/core/kmp_pkg.sv
// Shared types, codes and defaults of the keystroke macro player.
`timescale 1ns / 1ps

package kmp_pkg;

    // Default sizing of the macro store
    localparam int NUM_MACROS_DEF      = 16;
    localparam int STEPS_PER_MACRO_DEF = 32;

    // Step pointer width: holds any step position plus the wrap of the wait exit
    localparam int PTR_W = 6;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_PROCESS = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_COUNT   = 2'd2,
        KIND_TRIGGER = 2'd3
    } kind_t;

    // Stored step types; codes 5 to 7 are skipped during playback
    typedef enum logic [2:0] {
        STEP_END     = 3'd0,
        STEP_PRESS   = 3'd1,
        STEP_RELEASE = 3'd2,
        STEP_TAP     = 3'd3,
        STEP_DELAY   = 3'd4
    } step_kind_t;

    // Player mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_WAIT = 2'd2
    } mode_t;

    // Input transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  macro_sel;
        logic [4:0]  step_index;
        logic [2:0]  step_type;
        logic [15:0] step_key;
        logic [15:0] step_delay;
        logic [5:0]  step_total;
        logic [31:0] now_ms;
    } in_item_t;

    // Output transaction
    typedef struct packed {
        logic [15:0] key_code;
        logic        pressed;
        logic        last;
        logic        busy_res;
    } out_item_t;

    // One stored step entry (35 bits)
    typedef struct packed {
        logic [2:0]  step_type;
        logic [15:0] step_key;
        logic [15:0] step_delay;
    } step_t;

    // One buffered key event
    typedef struct packed {
        logic [15:0] key;
        logic        pressed;
    } evt_t;

    // Event write from the sequencer into the event buffer
    typedef struct packed {
        logic en;
        evt_t evt;
    } evt_wr_t;

    // End of a walk: hand the buffered events to the output side
    typedef struct packed {
        logic valid;
        logic busy;
    } commit_t;

endpackage

### rtl/core/kmp_step_mem.sv
// Step table: synchronous single-write, single-read memory of step entries.
`timescale 1ns / 1ps

module kmp_step_mem #(
    parameter int NUM_MACROS = kmp_pkg::NUM_MACROS_DEF,
    parameter int ADDR_W     = 10
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  kmp_pkg::step_t       wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output kmp_pkg::step_t       rdata
);
    import kmp_pkg::*;

    // Each macro owns a row of 2**PTR_W entries
    localparam int DEPTH = NUM_MACROS * (2 ** PTR_W);

    step_t step_mem [DEPTH];
    step_t rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            step_mem[waddr] <= wdata;
        end
        rdata_reg <= step_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/kmp_len_mem.sv
// Step count per macro: small memory with per-entry valid bits, reads zero until written.
`timescale 1ns / 1ps

module kmp_len_mem #(
    parameter int NUM_MACROS = kmp_pkg::NUM_MACROS_DEF,
    parameter int MID_W      = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [MID_W-1:0]              waddr,
    input  logic [kmp_pkg::PTR_W-1:0]     wdata,
    input  logic [MID_W-1:0]              raddr,
    output logic [kmp_pkg::PTR_W-1:0]     rdata
);
    import kmp_pkg::*;

    logic [PTR_W-1:0]      len_mem [NUM_MACROS];
    logic [NUM_MACROS-1:0] valid_reg;
    logic [PTR_W-1:0]      rdata_reg;

    // Valid bits: cleared by reset, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Storage and registered read; an unwritten entry reads as zero
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            len_mem[waddr] <= wdata;
        end
        rdata_reg <= valid_reg[raddr] ? len_mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/kmp_evt_buf.sv
// Event buffer: collects the key events of one walk, then drains them through the output register.
`timescale 1ns / 1ps

module kmp_evt_buf #(
    parameter int STEPS_PER_MACRO = kmp_pkg::STEPS_PER_MACRO_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kmp_pkg::evt_wr_t     evt_wr,
    input  kmp_pkg::commit_t     commit,
    output logic                 drain_busy,
    output logic                 result_valid,
    input  logic                 result_ready,
    output kmp_pkg::out_item_t   result
);
    import kmp_pkg::*;

    // One owed release plus one event per step
    localparam int DEPTH = STEPS_PER_MACRO + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    evt_t       evt_mem [DEPTH];
    logic [CNT_W-1:0] wr_cnt_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic       busy_reg;
    logic       q_valid_reg;
    logic       q_last_reg;
    evt_t       q_data_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    logic take;
    logic load;
    logic issue;

    // Drain handshake: read stage feeds the output register
    assign take  = out_valid_reg & result_ready;
    assign load  = q_valid_reg & (~out_valid_reg | take);
    assign issue = (rd_ptr_reg != cnt_reg) & (~q_valid_reg | load);

    assign drain_busy   = (rd_ptr_reg != cnt_reg) | q_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Event memory with registered read
    always_ff @(posedge clk)
    begin
        if (evt_wr.en)
        begin
            evt_mem[wr_cnt_reg[IDX_W-1:0]] <= evt_wr.evt;
        end
        if (issue)
        begin
            q_data_reg <= evt_mem[rd_ptr_reg[IDX_W-1:0]];
            q_last_reg <= ((rd_ptr_reg + CNT_W'(1)) == cnt_reg);
        end
        if (load)
        begin
            out_reg.key_code <= q_data_reg.key;
            out_reg.pressed  <= q_data_reg.pressed;
            out_reg.last     <= q_last_reg;
            out_reg.busy_res <= busy_reg;
        end
    end

    // Fill and drain pointers, valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_cnt_reg    <= '0;
            cnt_reg       <= '0;
            rd_ptr_reg    <= '0;
            busy_reg      <= 1'b0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit.valid)
            begin
                cnt_reg    <= wr_cnt_reg;
                wr_cnt_reg <= '0;
                rd_ptr_reg <= '0;
                busy_reg   <= commit.busy;
            end
            else
            begin
                if (evt_wr.en)
                begin
                    wr_cnt_reg <= wr_cnt_reg + CNT_W'(1);
                end
                if (issue)
                begin
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                end
            end
            q_valid_reg   <= issue | (q_valid_reg & ~load);
            out_valid_reg <= load | (out_valid_reg & ~take);
        end
    end

endmodule

### rtl/core/keystroke_macro_player.sv
// Keystroke macro player top level: item sequencer around the step and count memories.
//
//  channel  | signals                                   | accepted when
//  ---------+-------------------------------------------+------------------------------
//  item     | item_valid, item_ready, item (in_item_t)  | item_valid & item_ready
//  result   | result_valid, result_ready, result        | result_valid & result_ready
//
// Write-step and set-count transactions are done at acceptance; a trigger checks the count in S_TRIG.
// A process transaction fetches the count (S_PLEN), writes an owed release (S_OWED),
// walks one step per cycle (S_STEP, one step-table read each) until the count or a step
// ends the walk, and commits (S_DONE); its events then drain at one per cycle while
// result_ready does not hold the output register.
// The next transaction is taken once all events of the previous one left the buffer's read stage.
// Reset clears the player state and the count valid bits; the step table is not cleared.
// A stalled result holds the drain only; the walk itself never waits on result_ready.
`timescale 1ns / 1ps

module keystroke_macro_player #(
    parameter int NUM_MACROS      = kmp_pkg::NUM_MACROS_DEF,
    parameter int STEPS_PER_MACRO = kmp_pkg::STEPS_PER_MACRO_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  kmp_pkg::in_item_t    item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output kmp_pkg::out_item_t   result
);
    import kmp_pkg::*;

    localparam int MID_W  = (NUM_MACROS > 1) ? $clog2(NUM_MACROS) : 1;
    localparam int ADDR_W = MID_W + PTR_W;
    localparam logic [PTR_W-1:0] STEP_LIM = PTR_W'(STEPS_PER_MACRO);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TRIG = 6'b000010,
        S_PLEN = 6'b000100,
        S_OWED = 6'b001000,
        S_STEP = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t            state_reg,      state_next;
    mode_t             mode_reg,       mode_next;
    logic [MID_W-1:0]  active_reg,     active_next;
    logic [PTR_W-1:0]  ptr_reg,        ptr_next;
    logic [31:0]       wait_start_reg, wait_start_next;
    logic [15:0]       wait_len_reg,   wait_len_next;
    logic              owed_reg,       owed_next;
    logic [PTR_W-1:0]  len_reg,        len_next;
    in_item_t          item_reg;

    logic              item_accept;
    logic              drain_busy;
    logic              step_we;
    logic              len_we;
    logic [ADDR_W-1:0] step_waddr;
    step_t             step_wdata;
    logic [PTR_W-1:0]  rd_ptr;
    logic [MID_W-1:0]  len_raddr;
    step_t             step_q;
    logic [PTR_W-1:0]  len_q;
    logic [PTR_W-1:0]  ptr_eff;
    logic [31:0]       elapsed;
    logic              still_waiting;
    logic              trig_ok;
    logic              in_bounds;
    evt_wr_t           evt_wr;
    commit_t           commit;

    // Input handshake and direct table writes
    assign item_ready  = (state_reg == S_IDLE) & ~drain_busy;
    assign item_accept = item_valid & item_ready;

    assign step_we = item_accept && (item.kind == KIND_WRITE)
                     && (32'(item.macro_sel) < NUM_MACROS)
                     && (32'(item.step_index) < STEPS_PER_MACRO);
    assign step_waddr = {MID_W'(item.macro_sel), PTR_W'(item.step_index)};
    assign step_wdata = '{step_type:  item.step_type,
                          step_key:   item.step_key,
                          step_delay: item.step_delay};

    assign len_we = item_accept && (item.kind == KIND_COUNT)
                    && (32'(item.macro_sel) < NUM_MACROS)
                    && (32'(item.step_total) <= STEPS_PER_MACRO);

    // Count read: the trigger's slot on a trigger, else the playing macro
    assign len_raddr = (state_reg == S_IDLE && item.kind == KIND_TRIGGER)
                       ? MID_W'(item.macro_sel) : active_reg;

    // Wait check with wrapping time difference
    assign elapsed       = item_reg.now_ms - wait_start_reg;
    assign still_waiting = elapsed < {16'd0, wait_len_reg};
    assign ptr_eff       = (mode_reg == MODE_WAIT) ? ptr_reg + PTR_W'(1) : ptr_reg;
    assign trig_ok       = (32'(item_reg.macro_sel) < NUM_MACROS) && (len_q != '0);
    assign in_bounds     = (ptr_reg < len_reg) && (ptr_reg < STEP_LIM);

    kmp_step_mem #(
        .NUM_MACROS (NUM_MACROS),
        .ADDR_W     (ADDR_W)
    ) u_step_mem (
        .clk   (clk),
        .we    (step_we),
        .waddr (step_waddr),
        .wdata (step_wdata),
        .raddr ({active_reg, rd_ptr}),
        .rdata (step_q)
    );

    kmp_len_mem #(
        .NUM_MACROS (NUM_MACROS),
        .MID_W      (MID_W)
    ) u_len_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (len_we),
        .waddr (MID_W'(item.macro_sel)),
        .wdata (item.step_total),
        .raddr (len_raddr),
        .rdata (len_q)
    );

    kmp_evt_buf #(
        .STEPS_PER_MACRO (STEPS_PER_MACRO)
    ) u_evt_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt_wr       (evt_wr),
        .commit       (commit),
        .drain_busy   (drain_busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Sequencer: trigger check, count fetch, owed release, one step per cycle, commit
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        active_next     = active_reg;
        ptr_next        = ptr_reg;
        wait_start_next = wait_start_reg;
        wait_len_next   = wait_len_reg;
        owed_next       = owed_reg;
        len_next        = len_reg;
        rd_ptr          = ptr_reg;
        evt_wr          = '0;
        commit          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    case (item.kind)
                        KIND_TRIGGER: state_next = S_TRIG;
                        KIND_PROCESS: state_next = S_PLEN;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end

            S_TRIG:
            begin
                if (trig_ok)
                begin
                    active_next     = MID_W'(item_reg.macro_sel);
                    ptr_next        = '0;
                    mode_next       = MODE_RUN;
                    owed_next       = 1'b0;
                    wait_len_next   = '0;
                    wait_start_next = '0;
                end
                state_next = S_IDLE;
            end

            S_PLEN:
            begin
                len_next = len_q;
                if (mode_reg == MODE_IDLE || (mode_reg == MODE_WAIT && still_waiting))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mode_next = MODE_RUN;
                    ptr_next  = ptr_eff;
                    rd_ptr    = ptr_eff;
                    state_next = S_STEP;
                    if (owed_reg)
                    begin
                        owed_next = 1'b0;
                        // No release owed for a tap before step zero
                        if (ptr_eff != '0)
                        begin
                            rd_ptr     = ptr_eff - PTR_W'(1);
                            state_next = S_OWED;
                        end
                    end
                end
            end

            S_OWED:
            begin
                evt_wr.en          = 1'b1;
                evt_wr.evt.key     = step_q.step_key;
                evt_wr.evt.pressed = 1'b0;
                rd_ptr             = ptr_reg;
                state_next         = S_STEP;
            end

            S_STEP:
            begin
                rd_ptr = ptr_reg + PTR_W'(1);
                if (!in_bounds)
                begin
                    mode_next  = MODE_IDLE;
                    state_next = S_DONE;
                end
                else
                begin
                    case (step_q.step_type)
                        STEP_END:
                        begin
                            mode_next  = MODE_IDLE;
                            state_next = S_DONE;
                        end
                        STEP_PRESS:
                        begin
                            evt_wr.en          = 1'b1;
                            evt_wr.evt.key     = step_q.step_key;
                            evt_wr.evt.pressed = 1'b1;
                            ptr_next           = ptr_reg + PTR_W'(1);
                        end
                        STEP_RELEASE:
                        begin
                            evt_wr.en          = 1'b1;
                            evt_wr.evt.key     = step_q.step_key;
                            evt_wr.evt.pressed = 1'b0;
                            ptr_next           = ptr_reg + PTR_W'(1);
                        end
                        STEP_TAP:
                        begin
                            evt_wr.en          = 1'b1;
                            evt_wr.evt.key     = step_q.step_key;
                            evt_wr.evt.pressed = 1'b1;
                            ptr_next           = ptr_reg + PTR_W'(1);
                            owed_next          = 1'b1;
                            state_next         = S_DONE;
                        end
                        STEP_DELAY:
                        begin
                            if (step_q.step_delay != '0)
                            begin
                                mode_next       = MODE_WAIT;
                                wait_start_next = item_reg.now_ms;
                                wait_len_next   = step_q.step_delay;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                ptr_next = ptr_reg + PTR_W'(1);
                            end
                        end
                        default:
                        begin
                            ptr_next = ptr_reg + PTR_W'(1);
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                commit.valid = 1'b1;
                commit.busy  = (mode_reg != MODE_IDLE);
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and player state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_IDLE;
            active_reg     <= '0;
            ptr_reg        <= '0;
            wait_start_reg <= '0;
            wait_len_reg   <= '0;
            owed_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            active_reg     <= active_next;
            ptr_reg        <= ptr_next;
            wait_start_reg <= wait_start_next;
            wait_len_reg   <= wait_len_next;
            owed_reg       <= owed_next;
        end
    end

    // Transaction payload and walk length
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg <= item;
        end
        len_reg <= len_next;
    end

`ifndef SYNTHESIS
    a_commit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !drain_busy)
        else $error("commit while the event buffer still drains");

    a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_WAIT) |-> (wait_len_reg != '0))
        else $error("waiting on a zero delay");

    a_owed_running: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg |-> (mode_reg == MODE_RUN))
        else $error("tap release owed while not running");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (ptr_reg <= STEP_LIM))
        else $error("step pointer past the macro end");
`endif

endmodule
